FILE: hdl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, widths and constants of the 3x3 box blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4096;

   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int ROW_W          = 12;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd1024;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   localparam int CHAN_W       = 8;
   localparam int PIXEL_W      = 3 * CHAN_W;
   localparam int WINDOW_TAPS  = 9;
   localparam int SUM_W        = 12;   // 9 * 255 fits
   localparam int CNT_W        = 4;
   localparam int NUM_W        = SUM_W + 1;
   localparam int RECIP_W      = 18;
   localparam int RECIP_SHIFT  = 18;
   localparam int PROD_W       = NUM_W + RECIP_W;

   localparam int JOB_DEPTH  = 4;
   localparam int JOB_CNT_W  = $clog2(JOB_DEPTH + 1);
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   // what the back end does with one column push
   typedef struct packed {
      logic emit_a;   // result for the column before the newest
      logic full_a;   // that result spans all three columns
      logic emit_b;   // result for the newest column (row end)
      logic two_b;    // that result spans two columns, else one
      logic top_ok;
      logic bot_ok;
      logic last;     // second result closes the frame
   } job_flags_type;

   typedef struct packed {
      column_type    col;
      job_flags_type flags;
   } job_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } result_type;

   // ceil(2^18 / (2*cnt)); exact floor division for numerators below 2^18/18
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         4'd1:    r = 18'd131072;
         4'd2:    r = 18'd65536;
         4'd3:    r = 18'd43691;
         4'd4:    r = 18'd32768;
         4'd5:    r = 18'd26215;
         4'd6:    r = 18'd21846;
         4'd7:    r = 18'd18725;
         4'd8:    r = 18'd16384;
         4'd9:    r = 18'd14564;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bb3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bb3_fifo.sv
// ----------------------------------------------------------------------------
// bb3_fifo
// Small register FIFO with occupancy count; head word shown combinationally.
// ----------------------------------------------------------------------------
module bb3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

FILE: hdl/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Input side: config registers, raster counters, line stores. Classifies each
// word and hands one column job per pixel or flush it does not drop to the queue.
// ----------------------------------------------------------------------------
module bb3_front
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [CHAN_W-1:0]         req_in_red,
   input  logic [CHAN_W-1:0]         req_in_green,
   input  logic [CHAN_W-1:0]         req_in_blue,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic [JOB_CNT_W-1:0]      job_count,
   output logic                      job_push,
   output job_type                   job_data
);

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [FRAME_WIDTH_W-1:0]  frame_width_ff, frame_width_in;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff, frame_height_in;
   logic [ADDR_W-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      wait_ff, wait_in;   // all rows in, awaiting flush

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_pixel_ff, s1_pixel_in;
   logic                      s1_fwd_ff, s1_fwd_in;
   logic [ADDR_W-1:0]         s1_addr_ff, s1_addr_in;
   pixel_type                 s1_px_ff, s1_px_in;
   job_flags_type             s1_flags_ff, s1_flags_in;
   pixel_type                 fwd_upper_ff, fwd_upper_in;
   pixel_type                 fwd_middle_ff, fwd_middle_in;

   logic [ADDR_W-1:0]         last_col;
   logic [ROW_W-1:0]          last_row;
   logic [JOB_CNT_W-1:0]      occupancy;
   logic                      accept, is_pixel, take, at_last_col;
   logic                      col_nz, col_ge2, row_nz, row_ge2;
   logic                      line_wr_en;
   pixel_type                 upper_rd, middle_rd, top_px, mid_px;

   // effective width and height, clamped to the supported range
   always_comb begin
      if (frame_width_ff == '0) begin
         last_col = '0;
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         last_col = ADDR_W'(MAX_WIDTH - 1);
      end else begin
         last_col = ADDR_W'(frame_width_ff - FRAME_WIDTH_W'(1));
      end
      if (frame_height_ff == '0) begin
         last_row = '0;
      end else if (frame_height_ff > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
         last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         last_row = ROW_W'(frame_height_ff - FRAME_HEIGHT_W'(1));
      end
   end

   // the word accepted now and the one in stage 1 both land in the queue
   assign occupancy = job_count + JOB_CNT_W'(s1_valid_ff);
   assign req_stall = (occupancy >= JOB_CNT_W'(JOB_DEPTH));

   assign accept      = req_valid && !req_stall;
   assign is_pixel    = (req_cmd == CMD_PIXEL);
   assign take        = accept && (is_pixel ? !wait_ff : wait_ff);
   assign at_last_col = (col_ff == last_col);
   assign col_nz      = (col_ff != '0);
   assign col_ge2     = col_nz && (col_ff != ADDR_W'(1));
   assign row_nz      = (row_ff != '0);
   assign row_ge2     = (row_ff[ROW_W-1:1] != '0);

   always_comb begin
      col_in          = col_ff;
      row_in          = row_ff;
      wait_in         = wait_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (take) begin
         if (at_last_col) begin
            col_in = '0;
            if (!is_pixel) begin
               row_in  = '0;
               wait_in = 1'b0;
            end else if (row_ff == last_row) begin
               row_in  = '0;
               wait_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_write_data[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_write_data[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
         // a write to a known register abandons the frame
         if (csr_index inside {CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT}) begin
            col_in  = '0;
            row_in  = '0;
            wait_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in        = take;
      s1_pixel_in        = is_pixel;
      s1_addr_in         = col_ff;
      s1_px_in           = {req_in_red, req_in_green, req_in_blue};
      // the line entry read now is being rewritten by the word in stage 1
      s1_fwd_in          = s1_valid_ff && s1_pixel_ff && (s1_addr_ff == col_ff);
      s1_flags_in.emit_a = is_pixel ? (row_nz && col_nz) : col_nz;
      s1_flags_in.full_a = col_ge2;
      s1_flags_in.emit_b = is_pixel ? (row_nz && at_last_col) : at_last_col;
      s1_flags_in.two_b  = col_nz;
      s1_flags_in.top_ok = is_pixel ? row_ge2 : (last_row != '0);
      s1_flags_in.bot_ok = is_pixel;
      s1_flags_in.last   = !is_pixel;
   end

   bb3_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper_line (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mid_px),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   bb3_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle_line (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_px_ff),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (middle_rd)
   );

   assign top_px     = s1_fwd_ff ? fwd_upper_ff  : upper_rd;
   assign mid_px     = s1_fwd_ff ? fwd_middle_ff : middle_rd;
   assign line_wr_en = s1_valid_ff && s1_pixel_ff;

   always_comb begin
      fwd_upper_in  = fwd_upper_ff;
      fwd_middle_in = fwd_middle_ff;
      if (line_wr_en) begin
         fwd_upper_in  = mid_px;
         fwd_middle_in = s1_px_ff;
      end
   end

   assign job_push       = s1_valid_ff;
   assign job_data.col   = '{top: top_px, mid: mid_px, bot: (s1_pixel_ff ? s1_px_ff : '0)};
   assign job_data.flags = s1_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         wait_ff         <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         wait_ff         <= wait_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff   <= s1_pixel_in;
      s1_fwd_ff     <= s1_fwd_in;
      s1_addr_ff    <= s1_addr_in;
      s1_px_ff      <= s1_px_in;
      s1_flags_ff   <= s1_flags_in;
      fwd_upper_ff  <= fwd_upper_in;
      fwd_middle_ff <= fwd_middle_in;
   end

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col)
      else $error("column counter beyond row end");

   a_early_flush_dropped: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_FLUSH) && !wait_ff |=> !s1_valid_ff)
      else $error("flush before last row produced a job");

endmodule

FILE: hdl/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Execution side: 3x3 window, masked channel sums, divide by the tap count
// through a reciprocal multiply, and the result output buffer.
// ----------------------------------------------------------------------------
module bb3_back
   import bb3_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  job_type           job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAN_W-1:0] rsp_out_red,
   output logic [CHAN_W-1:0] rsp_out_green,
   output logic [CHAN_W-1:0] rsp_out_blue,
   output logic              rsp_last_in_frame
);

   column_type        win_ff [3];    // slot 2 newest
   column_type        win_in [3];
   job_flags_type     cur_ff, cur_in;
   logic              pend_a_ff, pend_a_in;
   logic              pend_b_ff, pend_b_in;

   logic              s1_v_ff;
   logic [SUM_W-1:0]  s1_sum_ff [3];
   logic [SUM_W-1:0]  s1_sum_in [3];
   logic [CNT_W-1:0]  s1_cnt_ff, s1_cnt_in;
   logic              s1_last_ff;
   logic              s2_v_ff;
   result_type        s2_res_ff, s2_res_in;

   logic [OUT_CNT_W-1:0] out_count, out_load;
   logic              credit_ok, issue_a, issue_b, issue, rem_a, rem_b;
   logic              out_pop;
   logic [2:0]        col_en, row_en;
   pixel_type         tap [3][3];
   logic [RECIP_W-1:0] s1_recip;
   logic [NUM_W-1:0]  num [3];
   logic [PROD_W-1:0] prod [3];
   result_type        head;

   assign out_load  = out_count + OUT_CNT_W'(s1_v_ff) + OUT_CNT_W'(s2_v_ff);
   assign credit_ok = (out_load < OUT_CNT_W'(OUT_DEPTH));
   assign issue_a   = pend_a_ff && credit_ok;
   assign issue_b   = !pend_a_ff && pend_b_ff && credit_ok;
   assign issue     = issue_a || issue_b;
   assign rem_a     = pend_a_ff && !issue_a;
   assign rem_b     = pend_b_ff && !issue_b;
   // next column may enter while the last result of this one is issued
   assign job_pop   = job_valid && !rem_a && !rem_b;

   always_comb begin
      win_in    = win_ff;
      cur_in    = cur_ff;
      pend_a_in = rem_a;
      pend_b_in = rem_b;
      if (job_pop) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = job_data.col;
         cur_in    = job_data.flags;
         pend_a_in = job_data.flags.emit_a;
         pend_b_in = job_data.flags.emit_b;
      end
   end

   always_comb begin
      for (int s = 0; s < 3; s++) begin
         tap[s][0] = win_ff[s].top;
         tap[s][1] = win_ff[s].mid;
         tap[s][2] = win_ff[s].bot;
      end
   end

   // masked sums over the window
   always_comb begin
      col_en[0] = issue_a && cur_ff.full_a;
      col_en[1] = issue_a || cur_ff.two_b;
      col_en[2] = 1'b1;
      row_en[0] = cur_ff.top_ok;
      row_en[1] = 1'b1;
      row_en[2] = cur_ff.bot_ok;
      s1_cnt_in = '0;
      for (int c = 0; c < 3; c++) begin
         s1_sum_in[c] = '0;
      end
      for (int s = 0; s < 3; s++) begin
         for (int r = 0; r < 3; r++) begin
            if (col_en[s] && row_en[r]) begin
               s1_sum_in[0] = s1_sum_in[0] + SUM_W'(tap[s][r][2*CHAN_W +: CHAN_W]);
               s1_sum_in[1] = s1_sum_in[1] + SUM_W'(tap[s][r][CHAN_W +: CHAN_W]);
               s1_sum_in[2] = s1_sum_in[2] + SUM_W'(tap[s][r][0 +: CHAN_W]);
               s1_cnt_in    = s1_cnt_in + CNT_W'(1);
            end
         end
      end
   end

   // (2*sum + cnt) / (2*cnt) via reciprocal
   assign s1_recip = recip(s1_cnt_ff);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num[c]  = {s1_sum_ff[c], 1'b0} + NUM_W'(s1_cnt_ff);
         prod[c] = PROD_W'(num[c]) * PROD_W'(s1_recip);
      end
      s2_res_in.red   = prod[0][RECIP_SHIFT +: CHAN_W];
      s2_res_in.green = prod[1][RECIP_SHIFT +: CHAN_W];
      s2_res_in.blue  = prod[2][RECIP_SHIFT +: CHAN_W];
      s2_res_in.last  = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
      end else begin
         pend_a_ff <= pend_a_in;
         pend_b_ff <= pend_b_in;
         s1_v_ff   <= issue;
         s2_v_ff   <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff     <= win_in;
      cur_ff     <= cur_in;
      s1_sum_ff  <= s1_sum_in;
      s1_cnt_ff  <= s1_cnt_in;
      s1_last_ff <= issue_b && cur_ff.last;
      s2_res_ff  <= s2_res_in;
   end

   assign out_pop = rsp_valid && !rsp_stall;

   bb3_fifo #(.WIDTH($bits(result_type)), .DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_v_ff),
      .push_data (s2_res_ff),
      .pop       (out_pop),
      .pop_valid (rsp_valid),
      .pop_data  (head),
      .count     (out_count)
   );

   assign rsp_out_red       = head.red;
   assign rsp_out_green     = head.green;
   assign rsp_out_blue      = head.blue;
   assign rsp_last_in_frame = head.last;

   a_tap_count: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (s1_cnt_ff != '0) && (s1_cnt_ff <= CNT_W'(WINDOW_TAPS)))
      else $error("tap count out of range");

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> (out_count < OUT_CNT_W'(OUT_DEPTH)) || out_pop)
      else $error("result buffer overflow");

endmodule

FILE: hdl/box_blur_3x3_edge_normalized_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized_core
// 3x3 box blur of an RGB raster stream, mean taken over in-frame taps only.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  : one word per pixel in raster order (req_cmd = pixel), then
//           frame_width flush words (req_cmd = flush) to drain the last row.
//           Pixels while flush is awaited and early flushes are dropped.
//  rsp_*  : blurred pixels in raster order; rsp_last_in_frame marks the
//           bottom-right pixel. Output trails input by one row and one column.
//  csr_*  : frame_width (index 0) and frame_height (index 1). A write to
//           either restarts the frame; write only while the core is idle.
// Throughput: one word per clock when not stalled. A word ending a row yields
//  two results and holds the back end until both issue; the queue absorbs it.
// Path: a result reaches rsp_valid from the word that completes its window
//  through line store read, queue, window sum and divide.
// Reset: counters cleared, frame size 1024x1024, queues empty. Line stores
//  are not cleared; entries are always written before their use.
// Stall: rsp_stall holds the head result; once the 4-deep result buffer and
//  the 4-deep job queue fill, req_stall rises.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized_core
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [CHAN_W-1:0]      req_in_red,
   input  logic [CHAN_W-1:0]      req_in_green,
   input  logic [CHAN_W-1:0]      req_in_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAN_W-1:0]      rsp_out_red,
   output logic [CHAN_W-1:0]      rsp_out_green,
   output logic [CHAN_W-1:0]      rsp_out_blue,
   output logic                   rsp_last_in_frame,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic                 job_push, job_pop, job_valid;
   logic [JOB_CNT_W-1:0] job_count;
   job_type              job_in, job_out;

   bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_in_red       (req_in_red),
      .req_in_green     (req_in_green),
      .req_in_blue      (req_in_blue),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .job_count        (job_count),
      .job_push         (job_push),
      .job_data         (job_in)
   );

   bb3_fifo #(.WIDTH($bits(job_type)), .DEPTH(JOB_DEPTH)) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  (job_out),
      .count     (job_count)
   );

   bb3_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job_data          (job_out),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_last_in_frame (rsp_last_in_frame)
   );

endmodule

FILE: test/tb_box_blur_3x3_edge_normalized_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_normalized_core
// Self-checking bench for the 3x3 edge-normalized box blur core. Frames of
// random RGB data are streamed in raster order and drained with flush words.
// Each blurred pixel is checked against a behavioral line-store and window
// predictor kept in a small scoreboard. Both sides idle at random, frame
// sizes range from 1x1 up to the clamped extremes, and broken frames
// (abandoned, early flushes, stray pixels) are mixed in.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_normalized_core;
   import bb3_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int IDLE_PCT      = 29;
   localparam int RANDOM_WORDS  = 860;
   localparam int EXTREME_WORDS = 40;    // pixels sent into each clamped frame
   localparam int PIPE_PAD      = 12;    // idle margin after drain before a register write
   localparam int STALL_LIMIT   = 2000;
   localparam int END_TAIL      = 20;

   // indexes past the register list
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // Line-store and window model of the blur, plus the store of blurred
   // pixels still owed by the core.
   class blur_scoreboard;
      pixel_type upper_row [MAX_WIDTH_DEFAULT];
      pixel_type middle_row [MAX_WIDTH_DEFAULT];
      pixel_type win [9] = '{default: '0};   // slot*3 + row, slot 2 newest
      int unsigned col_idx, row_idx, flush_idx;
      logic [FRAME_WIDTH_W-1:0]  width_reg  = FRAME_WIDTH_RESET;
      logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RESET;
      result_type blur_queue [$];
      int unsigned checked, errors, frames_done;

      function int unsigned cols();
         if (width_reg == 0) return 1;
         return (width_reg > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : width_reg;
      endfunction

      function int unsigned rows();
         if (height_reg == 0) return 1;
         return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      endfunction

      function int unsigned pending();
         return blur_queue.size();
      endfunction

      function void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_FRAME_WIDTH) begin
            width_reg = data[FRAME_WIDTH_W-1:0];
         end else if (idx == CSR_FRAME_HEIGHT) begin
            height_reg = data;
         end else begin
            return;
         end
         col_idx   = 0;
         row_idx   = 0;
         flush_idx = 0;
      endfunction

      function void shift_in(pixel_type top, pixel_type mid, pixel_type bot);
         int i;
         for (i = 0; i < 6; i++) win[i] = win[i + 3];
         win[6] = top;
         win[7] = mid;
         win[8] = bot;
      endfunction

      // rounded mean of slots lo..2; top/bottom rows dropped at frame edges
      function result_type window_mean(int lo, bit top_ok, bit bot_ok, bit last);
         int unsigned sum_r, sum_g, sum_b, taps;
         int slot, tap_row;
         result_type res;
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         taps  = 0;
         for (slot = lo; slot <= 2; slot++) begin
            for (tap_row = 0; tap_row < 3; tap_row++) begin
               if ((tap_row == 0 && !top_ok) || (tap_row == 2 && !bot_ok)) continue;
               sum_r += win[slot*3 + tap_row][23:16];
               sum_g += win[slot*3 + tap_row][15:8];
               sum_b += win[slot*3 + tap_row][7:0];
               taps++;
            end
         end
         res.red   = CHAN_W'((2*sum_r + taps) / (2*taps));
         res.green = CHAN_W'((2*sum_g + taps) / (2*taps));
         res.blue  = CHAN_W'((2*sum_b + taps) / (2*taps));
         res.last  = last;
         return res;
      endfunction

      // returns 1 when the word changes state, 0 when the core drops it
      function bit note_word(cmd_type cmd, logic [CHAN_W-1:0] red, green, blue);
         int unsigned w, h, k;
         pixel_type t, m;
         w = cols();
         h = rows();
         if (cmd == CMD_PIXEL) begin
            if (row_idx >= h || col_idx >= w) return 0;
            t = upper_row[col_idx];
            m = middle_row[col_idx];
            upper_row[col_idx]  = m;
            middle_row[col_idx] = {red, green, blue};
            shift_in(t, m, {red, green, blue});
            if (row_idx >= 1) begin
               if (col_idx >= 1)
                  blur_queue.push_back(window_mean(col_idx >= 2 ? 0 : 1, row_idx >= 2, 1, 0));
               if (col_idx == w - 1)
                  blur_queue.push_back(window_mean(col_idx >= 1 ? 1 : 2, row_idx >= 2, 1, 0));
            end
            col_idx++;
            if (col_idx >= w) begin
               col_idx = 0;
               row_idx++;
            end
            return 1;
         end
         k = flush_idx;
         if (row_idx < h || k >= w) return 0;
         shift_in(upper_row[k], middle_row[k], '0);
         if (k >= 1)
            blur_queue.push_back(window_mean(k >= 2 ? 0 : 1, h >= 2, 0, 0));
         if (k == w - 1)
            blur_queue.push_back(window_mean(k >= 1 ? 1 : 2, h >= 2, 0, 1));
         if (k + 1 >= w) begin
            col_idx   = 0;
            row_idx   = 0;
            flush_idx = 0;
            frames_done++;
         end else begin
            flush_idx = k + 1;
         end
         return 1;
      endfunction

      function void check_result(logic [CHAN_W-1:0] red, green, blue, logic last);
         result_type want;
         checked++;
         if (blur_queue.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected blurred pixel #%0d: r=%0d g=%0d b=%0d last=%0b",
                        checked, red, green, blue, last);
            return;
         end
         want = blur_queue.pop_front();
         if (red !== want.red || green !== want.green || blue !== want.blue ||
             last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("blurred pixel #%0d: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                        checked, want.red, want.green, want.blue, want.last,
                        red, green, blue, last);
         end
      endfunction

      function void flag_leftover();
         if (blur_queue.size() != 0) begin
            $display("%0d blurred pixels never came out", blur_queue.size());
            errors += blur_queue.size();
         end
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_cmd          = CMD_PIXEL;
   logic [CHAN_W-1:0]      req_in_red       = '0;
   logic [CHAN_W-1:0]      req_in_green     = '0;
   logic [CHAN_W-1:0]      req_in_blue      = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [CHAN_W-1:0]      rsp_out_red;
   logic [CHAN_W-1:0]      rsp_out_green;
   logic [CHAN_W-1:0]      rsp_out_blue;
   logic                   rsp_last_in_frame;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   logic        steady = 1'b0;   // no idling on either side while set
   int unsigned words_sent, words_taken, settings_used, idle_cycles;

   blur_scoreboard blur_sb = new;

   box_blur_3x3_edge_normalized_core u_top (.*);

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         blur_sb.check_result(rsp_out_red, rsp_out_green, rsp_out_blue, rsp_last_in_frame);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("no word moved for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_word(input cmd_type cmd, input logic [CHAN_W-1:0] red, green, blue);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_in_red   <= red;
      req_in_green <= green;
      req_in_blue  <= blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (blur_sb.note_word(cmd, red, green, blue)) words_taken++;
   endtask

   task automatic send_pixel();
      send_word(CMD_PIXEL, CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                CHAN_W'($urandom_range(255)));
   endtask

   // channel bits of a flush word are don't-care, so randomize them too
   task automatic send_flush();
      send_word(CMD_FLUSH, CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                CHAN_W'($urandom_range(255)));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (blur_sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      blur_sb.apply_csr(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait for idle, sometimes write a spare index, then reprogram the frame size
   task automatic set_frame(input logic [CSR_DATA_W-1:0] width_data, height_data);
      drain();
      repeat (PIPE_PAD) @(posedge clock);
      if ($urandom_range(4) == 0)
         write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B,
                   CSR_DATA_W'($urandom_range(8191)));
      write_reg(CSR_FRAME_WIDTH, width_data);
      write_reg(CSR_FRAME_HEIGHT, height_data);
      settings_used++;
   endtask

   // one frame of random pixels plus its flush; some frames are broken on purpose
   task automatic run_frame(input int unsigned w, h, input bit clean, output bit whole);
      int unsigned mode, cut, i;
      mode  = clean ? 9 : $urandom_range(9);
      cut   = (mode == 0) ? $urandom_range(w*h - 1) : w*h;
      whole = (mode != 0);
      for (i = 0; i < cut; i++) begin
         if (mode == 1 && $urandom_range(19) == 0) send_flush();   // early flush
         if (mode == 2 && i == w*h/2) drain();
         send_pixel();
      end
      if (whole) begin
         if (mode == 1) repeat ($urandom_range(2, 1)) send_pixel();   // dropped
         for (i = 0; i < w; i++) send_flush();
         if (mode == 1 && $urandom_range(1) == 1) send_flush();       // dropped
      end
   endtask

   initial begin
      int unsigned i, w, h, base, waited;
      logic [CSR_DATA_W-1:0] width_data;
      bit whole;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size is 1024x1024: a few pixels give nothing, early flush dropped
      send_word(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
      send_word(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
      send_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
      send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00);

      // zero size clamps to 1x1; second pixel waits out the flush and is dropped
      set_frame('0, '0);
      send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
      send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

      // 3x3 of extreme values: corners, edges and the full window; early flush dropped
      set_frame(13'd3, 13'd3);
      for (i = 0; i < 9; i++) begin
         if (i == 2) send_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
         send_word(CMD_PIXEL, (i % 2) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00,
                   (i == 4) ? 8'hFF : 8'h00);
      end
      for (i = 0; i < 3; i++) send_flush();

      // single row: first and last row at once
      set_frame(13'd2, 13'd1);
      send_word(CMD_PIXEL, 8'hFF, 8'h00, 8'h80);
      send_word(CMD_PIXEL, 8'h00, 8'hFF, 8'h7F);
      send_flush();
      send_flush();

      // random frames, mostly small, with a stretch of no idling in the middle
      base  = words_taken;
      whole = 0;
      w     = 1;
      h     = 1;
      while (words_taken < base + RANDOM_WORDS) begin
         steady <= (words_taken >= base + 300) && (words_taken < base + 560);
         if (!whole || $urandom_range(2) != 0) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
            h = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            width_data = CSR_DATA_W'(w);
            width_data[CSR_DATA_W-1:FRAME_WIDTH_W] = 2'($urandom_range(3));   // masked off
            set_frame(width_data, CSR_DATA_W'(h));
         end
         run_frame(w, h, 0, whole);
      end
      steady <= 1'b0;

      // all-ones writes clamp to the largest sizes; these frames are cut short,
      // the first abandoned by the next write, the second left unfinished
      set_frame('1, 13'd1);
      for (i = 0; i < EXTREME_WORDS; i++) send_pixel();   // row never completes
      set_frame(13'd1, '1);
      for (i = 0; i < EXTREME_WORDS; i++) send_pixel();

      req_valid <= 1'b0;
      waited = 0;
      while (blur_sb.pending() != 0 && waited < STALL_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (END_TAIL) @(posedge clock);
      blur_sb.flag_leftover();

      $display("%0d words sent (%0d used) across %0d frame sizes, %0d frames drained",
               words_sent, words_taken, settings_used, blur_sb.frames_done);
      $display("%0d blurred pixels checked, %0d errors; frames up to 64x20 plus clamped sizes",
               blur_sb.checked, blur_sb.errors);
      if (blur_sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
hdl/bb3_pkg.sv
hdl/bb3_ram.sv
hdl/bb3_fifo.sv
hdl/bb3_front.sv
hdl/bb3_back.sv
hdl/box_blur_3x3_edge_normalized_core.sv
test/tb_box_blur_3x3_edge_normalized_core.sv
